// ----- rtl/core/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and small helper functions shared by the JSON
// string escaper with UTF-8 repair.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] ASCII_TOP = 8'h80;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] E0_MIN   = 8'hA0;
  localparam logic [7:0] ED_MAX   = 8'h9F;
  localparam logic [7:0] F0_MIN   = 8'h90;
  localparam logic [7:0] F4_MAX   = 8'h8F;
  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam int unsigned SEQ_LEN = 6;
  localparam logic [2:0]  SEQ_LAST = 3'(SEQ_LEN - 1);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_OPEN  = 6'b000010,
    PH_PRE   = 6'b000100,
    PH_MID   = 6'b001000,
    PH_POST  = 6'b010000,
    PH_CLOSE = 6'b100000
  } ph_e;

  typedef struct packed {
    logic                           open;
    logic [1:0]                     pre_n;
    logic [2:0]                     mid_len;
    logic [SEQ_LEN-1:0][7:0]        mid;
    logic [1:0]                     post_n;
    logic                           close;
  } job_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b >= LEAD2_LO && b <= LEAD2_HI) r = 3'd2;
    if (b >= LEAD3_LO && b <= LEAD3_HI) r = 3'd3;
    if (b >= LEAD4_LO && b <= LEAD4_HI) r = 3'd4;
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_ZERO + {4'd0, n};
    else r = CH_LA + {4'd0, n} - 8'd10;
    return r;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = CH_BSLASH;
      3'd1: r = CH_U;
      3'd2: r = CH_F;
      3'd3: r = CH_F;
      3'd4: r = CH_F;
      3'd5: r = CH_D;
      default: r = CH_BSLASH;
    endcase
    return r;
  endfunction

  function automatic ph_e next_ph(input ph_e from, input job_t j);
    ph_e r;
    r = PH_IDLE;
    if (j.close && from != PH_CLOSE) r = PH_CLOSE;
    if (j.post_n != 2'd0 && (from == PH_IDLE || from == PH_OPEN || from == PH_PRE ||
                             from == PH_MID)) r = PH_POST;
    if (j.mid_len != 3'd0 && (from == PH_IDLE || from == PH_OPEN || from == PH_PRE))
      r = PH_MID;
    if (j.pre_n != 2'd0 && (from == PH_IDLE || from == PH_OPEN)) r = PH_PRE;
    if (j.open && from == PH_IDLE) r = PH_OPEN;
    return r;
  endfunction

endpackage

// ----- rtl/core/jse_if.sv -----
// ----------------------------------------------------------------------------
// jse_if
// Valid/ready stream interfaces for raw input bytes and escaped output bytes.
// ----------------------------------------------------------------------------
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input in_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

// ----- rtl/core/jse_plan.sv -----
// ----------------------------------------------------------------------------
// jse_plan
// UTF-8 sequence tracker: holds partial sequences and turns each accepted
// byte into an output job (opening quote, replacements, body, closing quote).
// ----------------------------------------------------------------------------
module jse_plan
  import jse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       first_i,
  input  logic       last_i,
  output job_t       job_o
);

  logic [7:0] pend_q [3];
  logic [1:0] pcnt_q, pcnt_d;
  logic [2:0] slen_q, slen_d;

  logic [1:0] pc, pc_n;
  logic [2:0] sl, sl_n, lead;
  logic       cont, do_fresh, wr0, wrn;
  logic [7:0] c;
  job_t       job;

  assign c    = in_byte_i;
  assign lead = lead_len(c);
  assign pc   = first_i ? 2'd0 : pcnt_q;
  assign sl   = first_i ? 3'd0 : slen_q;

  always_comb begin
    cont = (c[7:6] == CONT_TAG);
    if (pc == 2'd1) begin
      if (pend_q[0] == LEAD3_LO && c < E0_MIN) cont = 1'b0;
      if (pend_q[0] == LEAD_SURR && c > ED_MAX) cont = 1'b0;
      if (pend_q[0] == LEAD4_LO && c < F0_MIN) cont = 1'b0;
      if (pend_q[0] == LEAD4_HI && c > F4_MAX) cont = 1'b0;
    end
  end

  always_comb begin
    job       = '0;
    job.open  = first_i;
    job.close = last_i;
    pc_n      = pc;
    sl_n      = sl;
    do_fresh  = 1'b0;
    wr0       = 1'b0;
    wrn       = 1'b0;

    if (pc == 2'd0) begin
      do_fresh = 1'b1;
    end else if (cont) begin
      if ({1'b0, pc} + 3'd1 >= sl) begin
        job.mid_len = {1'b0, pc} + 3'd1;
        job.mid[0]  = pend_q[0];
        job.mid[1]  = (pc == 2'd1) ? c : pend_q[1];
        job.mid[2]  = (pc == 2'd2) ? c : pend_q[2];
        job.mid[3]  = c;
        pc_n        = 2'd0;
        sl_n        = 3'd0;
      end else begin
        wrn  = 1'b1;
        pc_n = pc + 2'd1;
      end
    end else begin
      job.pre_n = pc;
      pc_n      = 2'd0;
      sl_n      = 3'd0;
      do_fresh  = 1'b1;
    end

    if (do_fresh) begin
      if (c >= CH_SPACE && c < ASCII_TOP && c != CH_QUOTE && c != CH_BSLASH) begin
        job.mid_len = 3'd1;
        job.mid[0]  = c;
      end else if (c < ASCII_TOP) begin
        job.mid[0]  = CH_BSLASH;
        job.mid_len = 3'd2;
        case (c)
          CH_QUOTE:  job.mid[1] = CH_QUOTE;
          CH_BSLASH: job.mid[1] = CH_BSLASH;
          CH_LF:     job.mid[1] = CH_N;
          CH_CR:     job.mid[1] = CH_R;
          CH_TAB:    job.mid[1] = CH_T;
          default: begin
            job.mid_len = 3'(SEQ_LEN);
            job.mid[1]  = CH_U;
            job.mid[2]  = CH_ZERO;
            job.mid[3]  = CH_ZERO;
            job.mid[4]  = hex_digit(c[7:4]);
            job.mid[5]  = hex_digit(c[3:0]);
          end
        endcase
      end else if (lead != 3'd0) begin
        wr0  = 1'b1;
        pc_n = 2'd1;
        sl_n = lead;
      end else begin
        job.mid_len = 3'(SEQ_LEN);
        for (int k = 0; k < SEQ_LEN; k++) begin
          job.mid[k] = repl_byte(3'(k));
        end
      end
    end

    pcnt_d = pc_n;
    slen_d = sl_n;
    if (last_i) begin
      job.post_n = pc_n;
      pcnt_d     = 2'd0;
      slen_d     = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      slen_q <= 3'd0;
    end else if (accept_i) begin
      pcnt_q <= pcnt_d;
      slen_q <= slen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr0) pend_q[0] <= c;
    if (accept_i && wrn) pend_q[pc] <= c;
  end

  assign job_o = job;

endmodule

// ----- rtl/core/json_string_escaper_utf8_repair.sv -----
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_repair
// Quotes and escapes a byte stream as JSON string text, repairing bad UTF-8.
// ----------------------------------------------------------------------------
// Each input transaction expands into zero to 25 output bytes, which leave one
// per cycle, unless the output stalls, through a single registered output
// byte lane; that lane sets the rate. An input byte producing several results
// holds the input until its final byte is emitted; the next byte is taken in
// the same cycle its predecessor's final byte enters the output register, so
// plain text moves at one byte per cycle while the output is not stalled. A
// byte that is only held as part of a UTF-8 sequence produces nothing. run_end
// marks the final byte of each input's results, string_end the closing quote.
module json_string_escaper_utf8_repair
  import jse_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  jse_in_if.sink         in_i,
  jse_out_if.source      out_o
);

  job_t       job_d, job_q;
  ph_e        ph_q, ph_d, ph_nxt, ph_start;
  logic [2:0] chr_q, chr_d;
  logic [1:0] rep_q, rep_d;
  logic       emit, done, last_out, in_ready, accept;

  logic       out_vld_q;
  logic [7:0] out_byte_q, byte_sel;
  logic       run_end_q, string_end_q;

  jse_plan u_plan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .first_i   (in_i.first_byte),
    .last_i    (in_i.last_byte),
    .job_o     (job_d)
  );

  assign ph_nxt   = next_ph(ph_q, job_q);
  assign ph_start = next_ph(PH_IDLE, job_d);

  always_comb begin
    case (ph_q)
      PH_OPEN:  done = 1'b1;
      PH_PRE:   done = (chr_q == SEQ_LAST) && (rep_q == 2'd1);
      PH_MID:   done = (chr_q == job_q.mid_len - 3'd1);
      PH_POST:  done = (chr_q == SEQ_LAST) && (rep_q == 2'd1);
      PH_CLOSE: done = 1'b1;
      default:  done = 1'b0;
    endcase
  end

  always_comb begin
    case (ph_q)
      PH_OPEN:  byte_sel = CH_QUOTE;
      PH_PRE:   byte_sel = repl_byte(chr_q);
      PH_MID:   byte_sel = job_q.mid[chr_q];
      PH_POST:  byte_sel = repl_byte(chr_q);
      PH_CLOSE: byte_sel = CH_QUOTE;
      default:  byte_sel = CH_QUOTE;
    endcase
  end

  assign last_out = done && (ph_nxt == PH_IDLE);
  assign emit     = (ph_q != PH_IDLE) && (!out_vld_q || out_o.ready);
  assign in_ready = (ph_q == PH_IDLE) || (emit && last_out);
  assign accept   = in_i.valid && in_ready;

  always_comb begin
    ph_d  = ph_q;
    chr_d = chr_q;
    rep_d = rep_q;
    if (accept) begin
      ph_d  = ph_start;
      chr_d = 3'd0;
      rep_d = (ph_start == PH_PRE) ? job_d.pre_n : job_d.post_n;
    end else if (emit) begin
      if (done) begin
        ph_d  = ph_nxt;
        chr_d = 3'd0;
        rep_d = (ph_nxt == PH_PRE) ? job_q.pre_n : job_q.post_n;
      end else if ((ph_q == PH_PRE || ph_q == PH_POST) && chr_q == SEQ_LAST) begin
        chr_d = 3'd0;
        rep_d = rep_q - 2'd1;
      end else begin
        chr_d = chr_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_IDLE;
      chr_q     <= 3'd0;
      rep_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      chr_q <= chr_d;
      rep_q <= rep_d;
      if (emit) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) job_q <= job_d;
    if (emit) begin
      out_byte_q   <= byte_sel;
      run_end_q    <= last_out;
      string_end_q <= (ph_q == PH_CLOSE);
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_vld_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_end    = run_end_q;
  assign out_o.string_end = string_end_q;

endmodule

// ----- rtl/core/jse_checker.sv -----
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks for the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker
  import jse_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_end_i,
  input logic       string_end_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(run_end_i) && $stable(string_end_i))
    else $error("stalled output transaction changed");

  a_close_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_end_i && out_byte_i == CH_QUOTE)
    else $error("closing quote not final or not a quote");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("output started without a preceding input transaction");

endmodule

bind json_string_escaper_utf8_repair jse_checker u_jse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .run_end_i    (out_o.run_end),
  .string_end_i (out_o.string_end)
);
